// ===== design/assert_macros.svh =====
// Assertion macros used by the warp address map core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define QMW_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error("qmw assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define QMW_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error("qmw assertion failed");

`endif

// ===== design/qmw_pkg.sv =====
// Shared constants for the quad mesh warp address map.
package qmw_pkg;

    // Fixed field widths.
    localparam int PIX_W    = 12;
    localparam int DIM_W    = 13;
    localparam int OPCODE_W = 2;
    localparam int CIDX_W   = 2;
    localparam int CFG_IDX_W = 1;

    // Output beat: dest_col, dest_row, in_cell, fill_white, source_col, source_row.
    localparam int OUT_BITS   = 4 * PIX_W + 2;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Parameter defaults.
    localparam int COORD_INT_BITS_DEF   = 12;
    localparam int COORD_FRAC_BITS_DEF  = 8;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    // Image size after reset.
    localparam logic [DIM_W-1:0] IMG_DIM_RESET = 13'd4096;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_CELL   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CORNER = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MAP    = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

endpackage

// ===== design/quad_mesh_warp_address_map_core.sv =====
// Quad mesh warp inverse-mapping address generator, fully pipelined.
// Throughput: one beat per cycle while the output is not holding an untaken beat;
// the restoring divider gives one quotient bit per stage.
// Load beats update the cell and corner registers at acceptance and produce no result.
// aresetn (synchronous, active low) empties the pipeline, sets the image size to 4096
// and clears the cell bounds and corners to zero.
`include "assert_macros.svh"

module quad_mesh_warp_address_map_core #(
    parameter int COORD_INT_BITS   = qmw_pkg::COORD_INT_BITS_DEF,
    parameter int COORD_FRAC_BITS  = qmw_pkg::COORD_FRAC_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = qmw_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qmw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qmw_pkg::DIM_W-1:0]      cfg_data,
    // Input stream.
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // From bit 0: corner_index, corner_x, corner_y, cell_left, cell_top, cell_right,
    // cell_bottom, pixel_col, pixel_row, zero fill.
    input  logic [((2 + 6 * (COORD_INT_BITS + COORD_FRAC_BITS + 1) + 24 + 7) / 8) * 8 - 1:0]
                 s_axis_tdata,
    // From bit 0: opcode.
    input  logic [qmw_pkg::OPCODE_W-1:0] s_axis_tuser,
    // Result stream.
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // From bit 0: dest_col, dest_row, in_cell, fill_white, source_col, source_row, zero fill.
    output logic [qmw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int B   = WEIGHT_FRAC_BITS;
    localparam int CW  = COORD_INT_BITS + COORD_FRAC_BITS + 1;
    localparam int PW  = qmw_pkg::PIX_W;
    localparam int XW  = qmw_pkg::DIM_W + 1 + F;
    localparam int M1  = (CW > XW) ? CW : XW;
    localparam int M2  = (M1 > PW + F + 1) ? M1 : (PW + F + 1);
    localparam int NB  = M2 + 1;
    localparam int RW  = NB + B;
    localparam int EW  = NB + B + 5;
    localparam int QW  = B + 5;
    localparam int DS  = B + 5;
    localparam int WW  = B + 7;
    localparam int P1W = WW + CW;
    localparam int TW  = CW + 6;
    localparam int P2W = WW + TW;
    localparam int SW  = TW + 6;
    localparam int CMW = ((SW > NB) ? SW : NB) + 1;
    localparam int ID_W = ((2 + 6 * CW + 2 * PW + 7) / 8) * 8;

    // Input field offsets.
    localparam int O_CX  = qmw_pkg::CIDX_W;
    localparam int O_CY  = O_CX + CW;
    localparam int O_L   = O_CY + CW;
    localparam int O_T   = O_L + CW;
    localparam int O_R   = O_T + CW;
    localparam int O_B   = O_R + CW;
    localparam int O_COL = O_B + CW;
    localparam int O_ROW = O_COL + PW;

    typedef struct packed {
        logic [PW-1:0]         col;
        logic [PW-1:0]         row;
        logic                  in_cell;
        logic signed [CW-1:0]  cx0, cx1, cx2, cx3;
        logic signed [CW-1:0]  cy0, cy1, cy2, cy3;
        logic                  negx, negy, zerox, zeroy, satx, saty;
    } side_t;

    // Handshake: the whole pipeline moves unless the output holds an untaken beat.
    logic adv;
    logic acc;
    logic m_valid_reg;
    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign acc           = s_axis_tvalid && adv;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;

    // Input fields.
    logic [qmw_pkg::CIDX_W-1:0] in_ci;
    logic signed [CW-1:0] in_cx, in_cy, in_l, in_t, in_r, in_b;
    logic [PW-1:0] in_col, in_row;
    assign in_ci  = s_axis_tdata[qmw_pkg::CIDX_W-1:0];
    assign in_cx  = s_axis_tdata[O_CX +: CW];
    assign in_cy  = s_axis_tdata[O_CY +: CW];
    assign in_l   = s_axis_tdata[O_L +: CW];
    assign in_t   = s_axis_tdata[O_T +: CW];
    assign in_r   = s_axis_tdata[O_R +: CW];
    assign in_b   = s_axis_tdata[O_B +: CW];
    assign in_col = s_axis_tdata[O_COL +: PW];
    assign in_row = s_axis_tdata[O_ROW +: PW];

    // Configuration and cell/corner registers.
    logic [qmw_pkg::DIM_W-1:0] width_reg, height_reg;
    logic signed [CW-1:0] left_reg, top_reg, right_reg, bottom_reg;
    logic signed [CW-1:0] cx_reg [4];
    logic signed [CW-1:0] cy_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= qmw_pkg::IMG_DIM_RESET;
            height_reg <= qmw_pkg::IMG_DIM_RESET;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                cx_reg[i] <= '0;
                cy_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    qmw_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                    qmw_pkg::REG_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (acc) begin
                case (s_axis_tuser)
                    qmw_pkg::OP_CELL: begin
                        left_reg   <= in_l;
                        top_reg    <= in_t;
                        right_reg  <= in_r;
                        bottom_reg <= in_b;
                    end
                    qmw_pkg::OP_CORNER: begin
                        cx_reg[in_ci] <= in_cx;
                        cy_reg[in_ci] <= in_cy;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Image limits (W-1) << F and (H-1) << F.
    logic signed [NB-1:0] xmax, ymax;
    assign xmax = $signed((NB'(width_reg) - NB'(1)) << F);
    assign ymax = $signed((NB'(height_reg) - NB'(1)) << F);

    // Stage 0: clamp the cell edges and capture the corners.
    logic signed [NB-1:0] lft, tp, rgt, btm;
    logic signed [NB-1:0] x0_next, y0_next, x1_next, y1_next;
    assign lft = NB'(left_reg);
    assign tp  = NB'(top_reg);
    assign rgt = NB'(right_reg);
    assign btm = NB'(bottom_reg);
    assign x0_next = (lft < 0) ? '0 : lft;
    assign y0_next = (tp < 0) ? '0 : tp;
    assign x1_next = (rgt < xmax) ? rgt : xmax;
    assign y1_next = (btm < ymax) ? btm : ymax;

    logic v0_reg;
    logic signed [NB-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    side_t s0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v0_reg <= 1'b0;
        else if (adv) v0_reg <= acc && (s_axis_tuser == qmw_pkg::OP_MAP);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            s0_reg <= '{col: in_col, row: in_row, in_cell: 1'b0,
                        cx0: cx_reg[0], cx1: cx_reg[1], cx2: cx_reg[2], cx3: cx_reg[3],
                        cy0: cy_reg[0], cy1: cy_reg[1], cy2: cy_reg[2], cy3: cy_reg[3],
                        negx: 1'b0, negy: 1'b0, zerox: 1'b0, zeroy: 1'b0,
                        satx: 1'b0, saty: 1'b0};
        end
    end

    // Stage 1: raster test, weight numerators and spans.
    logic signed [NB-1:0] cpos, rpos, colw, roww;
    assign colw = $signed(NB'(s0_reg.col));
    assign roww = $signed(NB'(s0_reg.row));
    assign cpos = $signed(NB'(s0_reg.col) << F);
    assign rpos = $signed(NB'(s0_reg.row) << F);

    side_t s1_next;
    always_comb begin
        s1_next         = s0_reg;
        s1_next.in_cell = ((x0_reg >>> F) <= colw) && (cpos < x1_reg) &&
                          ((y0_reg >>> F) <= roww) && (rpos < y1_reg);
    end

    logic v1_reg;
    logic signed [NB-1:0] numx_reg, numy_reg, denx_reg, deny_reg;
    side_t s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= v0_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            numx_reg <= cpos - x0_reg;
            numy_reg <= rpos - y0_reg;
            denx_reg <= x1_reg - x0_reg;
            deny_reg <= y1_reg - y0_reg;
            s1_reg   <= s1_next;
        end
    end

    // Stage 2: magnitudes, signs and saturation test ahead of the divider.
    logic [NB-1:0] ax, ay, dxm, dym;
    assign ax  = numx_reg[NB-1] ? NB'(-numx_reg) : NB'(numx_reg);
    assign ay  = numy_reg[NB-1] ? NB'(-numy_reg) : NB'(numy_reg);
    assign dxm = denx_reg[NB-1] ? NB'(-denx_reg) : NB'(denx_reg);
    assign dym = deny_reg[NB-1] ? NB'(-deny_reg) : NB'(deny_reg);

    side_t sd_next;
    always_comb begin
        sd_next       = s1_reg;
        sd_next.negx  = numx_reg[NB-1] ^ denx_reg[NB-1];
        sd_next.negy  = numy_reg[NB-1] ^ deny_reg[NB-1];
        sd_next.zerox = (denx_reg == '0);
        sd_next.zeroy = (deny_reg == '0);
        sd_next.satx  = ((NB + 5)'(ax) >= ((NB + 5)'(dxm) << 5));
        sd_next.saty  = ((NB + 5)'(ay) >= ((NB + 5)'(dym) << 5));
    end

    logic          vd_reg   [0:DS];
    logic [RW-1:0] remx_reg [0:DS];
    logic [RW-1:0] remy_reg [0:DS];
    logic [QW-1:0] qx_reg   [0:DS];
    logic [QW-1:0] qy_reg   [0:DS];
    logic [NB-1:0] dx_reg   [0:DS];
    logic [NB-1:0] dy_reg   [0:DS];
    side_t         sd_reg   [0:DS];

    always_ff @(posedge aclk) begin
        if (!aresetn) vd_reg[0] <= 1'b0;
        else if (adv) vd_reg[0] <= v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            remx_reg[0] <= RW'(ax) << B;
            remy_reg[0] <= RW'(ay) << B;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            dx_reg[0]   <= dxm;
            dy_reg[0]   <= dym;
            sd_reg[0]   <= sd_next;
        end
    end

    // Restoring divider: one quotient bit per stage, most significant first.
    for (genvar k = 0; k < DS; k++) begin : g_div
        localparam int SH = DS - 1 - k;
        logic [EW-1:0] dshx, dshy;
        logic gex, gey;
        assign dshx = EW'(dx_reg[k]) << SH;
        assign dshy = EW'(dy_reg[k]) << SH;
        assign gex  = EW'(remx_reg[k]) >= dshx;
        assign gey  = EW'(remy_reg[k]) >= dshy;

        always_ff @(posedge aclk) begin
            if (!aresetn) vd_reg[k+1] <= 1'b0;
            else if (adv) vd_reg[k+1] <= vd_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                remx_reg[k+1] <= gex ? RW'(EW'(remx_reg[k]) - dshx) : remx_reg[k];
                remy_reg[k+1] <= gey ? RW'(EW'(remy_reg[k]) - dshy) : remy_reg[k];
                qx_reg[k+1]   <= {qx_reg[k][QW-2:0], gex};
                qy_reg[k+1]   <= {qy_reg[k][QW-2:0], gey};
                dx_reg[k+1]   <= dx_reg[k];
                dy_reg[k+1]   <= dy_reg[k];
                sd_reg[k+1]   <= sd_reg[k];
            end
        end
    end

    // Weight stage: saturate to sixteen, apply sign, zero span gives zero.
    localparam logic [QW-1:0] W_SAT = QW'(1) << (B + 4);
    side_t sq;
    logic [QW-1:0] magx, magy;
    logic signed [WW-1:0] wx_next, wy_next;
    assign sq   = sd_reg[DS];
    assign magx = (sq.satx || qx_reg[DS] > W_SAT) ? W_SAT : qx_reg[DS];
    assign magy = (sq.saty || qy_reg[DS] > W_SAT) ? W_SAT : qy_reg[DS];
    assign wx_next = sq.zerox ? '0 : (sq.negx ? -$signed(WW'(magx)) : $signed(WW'(magx)));
    assign wy_next = sq.zeroy ? '0 : (sq.negy ? -$signed(WW'(magy)) : $signed(WW'(magy)));

    logic vw_reg;
    logic signed [WW-1:0] wx_reg, wy_reg;
    side_t sw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vw_reg <= 1'b0;
        else if (adv) vw_reg <= vd_reg[DS];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wx_reg <= wx_next;
            wy_reg <= wy_next;
            sw_reg <= sq;
        end
    end

    // First blend, multiply stage: top and bottom edges in x and y.
    localparam logic signed [WW-1:0] W_ONE = $signed(WW'(1) << B);
    logic signed [WW-1:0] omx;
    assign omx = W_ONE - wx_reg;

    logic vm1_reg;
    logic signed [P1W-1:0] ptx0_reg, ptx1_reg, pty0_reg, pty1_reg;
    logic signed [P1W-1:0] pbx0_reg, pbx1_reg, pby0_reg, pby1_reg;
    logic signed [WW-1:0] wy1_reg;
    logic [PW-1:0] col1_reg, row1_reg;
    logic inside1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vm1_reg <= 1'b0;
        else if (adv) vm1_reg <= vw_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ptx0_reg <= P1W'(omx) * P1W'($signed(sw_reg.cx0));
            ptx1_reg <= P1W'(wx_reg) * P1W'($signed(sw_reg.cx1));
            pty0_reg <= P1W'(omx) * P1W'($signed(sw_reg.cy0));
            pty1_reg <= P1W'(wx_reg) * P1W'($signed(sw_reg.cy1));
            pbx0_reg <= P1W'(omx) * P1W'($signed(sw_reg.cx3));
            pbx1_reg <= P1W'(wx_reg) * P1W'($signed(sw_reg.cx2));
            pby0_reg <= P1W'(omx) * P1W'($signed(sw_reg.cy3));
            pby1_reg <= P1W'(wx_reg) * P1W'($signed(sw_reg.cy2));
            wy1_reg     <= wy_reg;
            col1_reg    <= sw_reg.col;
            row1_reg    <= sw_reg.row;
            inside1_reg <= sw_reg.in_cell;
        end
    end

    // First blend, sum and floor stage.
    logic signed [P1W:0] stx, sty, sbx, sby;
    logic signed [P1W:0] ftx, fty, fbx, fby;
    assign stx = (P1W + 1)'(ptx0_reg) + (P1W + 1)'(ptx1_reg);
    assign sty = (P1W + 1)'(pty0_reg) + (P1W + 1)'(pty1_reg);
    assign sbx = (P1W + 1)'(pbx0_reg) + (P1W + 1)'(pbx1_reg);
    assign sby = (P1W + 1)'(pby0_reg) + (P1W + 1)'(pby1_reg);
    assign ftx = stx >>> B;
    assign fty = sty >>> B;
    assign fbx = sbx >>> B;
    assign fby = sby >>> B;

    logic va1_reg;
    logic signed [TW-1:0] tx_reg, ty_reg, bx_reg, by_reg;
    logic signed [WW-1:0] wy2_reg;
    logic [PW-1:0] col2_reg, row2_reg;
    logic inside2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) va1_reg <= 1'b0;
        else if (adv) va1_reg <= vm1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tx_reg      <= ftx[TW-1:0];
            ty_reg      <= fty[TW-1:0];
            bx_reg      <= fbx[TW-1:0];
            by_reg      <= fby[TW-1:0];
            wy2_reg     <= wy1_reg;
            col2_reg    <= col1_reg;
            row2_reg    <= row1_reg;
            inside2_reg <= inside1_reg;
        end
    end

    // Second blend, multiply stage: vertical mix of top and bottom.
    logic signed [WW-1:0] omy;
    assign omy = W_ONE - wy2_reg;

    logic vm2_reg;
    logic signed [P2W-1:0] qsx0_reg, qsx1_reg, qsy0_reg, qsy1_reg;
    logic [PW-1:0] col3_reg, row3_reg;
    logic inside3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vm2_reg <= 1'b0;
        else if (adv) vm2_reg <= va1_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            qsx0_reg    <= P2W'(omy) * P2W'(tx_reg);
            qsx1_reg    <= P2W'(wy2_reg) * P2W'(bx_reg);
            qsy0_reg    <= P2W'(omy) * P2W'(ty_reg);
            qsy1_reg    <= P2W'(wy2_reg) * P2W'(by_reg);
            col3_reg    <= col2_reg;
            row3_reg    <= row2_reg;
            inside3_reg <= inside2_reg;
        end
    end

    // Second blend, sum and floor stage.
    logic signed [P2W:0] ssx, ssy, fsx, fsy;
    assign ssx = (P2W + 1)'(qsx0_reg) + (P2W + 1)'(qsx1_reg);
    assign ssy = (P2W + 1)'(qsy0_reg) + (P2W + 1)'(qsy1_reg);
    assign fsx = ssx >>> B;
    assign fsy = ssy >>> B;

    logic va2_reg;
    logic signed [SW-1:0] sx_reg, sy_reg;
    logic [PW-1:0] col4_reg, row4_reg;
    logic inside4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) va2_reg <= 1'b0;
        else if (adv) va2_reg <= vm2_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sx_reg      <= fsx[SW-1:0];
            sy_reg      <= fsy[SW-1:0];
            col4_reg    <= col3_reg;
            row4_reg    <= row3_reg;
            inside4_reg <= inside3_reg;
        end
    end

    // Output stage: image bounds test and source address.
    logic signed [CMW-1:0] sxe, sye, xme, yme;
    logic signed [SW-1:0] sxf, syf;
    logic fill_next;
    assign sxe = CMW'(sx_reg);
    assign sye = CMW'(sy_reg);
    assign xme = CMW'(xmax);
    assign yme = CMW'(ymax);
    assign sxf = sx_reg >>> F;
    assign syf = sy_reg >>> F;
    assign fill_next = inside4_reg && ((sxe < 0) || (sxe > xme) || (sye < 0) || (sye > yme));

    logic [PW-1:0] dcol_reg, drow_reg, scol_reg, srow_reg;
    logic inc_reg, fill_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) m_valid_reg <= 1'b0;
        else if (adv) m_valid_reg <= va2_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dcol_reg <= col4_reg;
            drow_reg <= row4_reg;
            inc_reg  <= inside4_reg;
            fill_reg <= fill_next;
            scol_reg <= (inside4_reg && !fill_next) ? sxf[PW-1:0] : '0;
            srow_reg <= (inside4_reg && !fill_next) ? syf[PW-1:0] : '0;
        end
    end

    assign m_axis_tdata = qmw_pkg::OUT_DATA_W'({srow_reg, scol_reg, fill_reg, inc_reg,
                                                drow_reg, dcol_reg});

    // Checks on the result formatting, the stall logic and load beats staying out of the pipeline.
    `QMW_ASSERT_IMP(a_outside_clean, m_valid_reg && !inc_reg,
                    !fill_reg && scol_reg == '0 && srow_reg == '0)
    `QMW_ASSERT_IMP(a_fill_clean, m_valid_reg && fill_reg,
                    inc_reg && scol_reg == '0 && srow_reg == '0)
    `QMW_ASSERT_IMP(a_ready_rule, 1'b1, s_axis_tready == (!m_valid_reg || m_axis_tready))
    `QMW_ASSERT_NXT(a_load_no_entry, acc && s_axis_tuser != qmw_pkg::OP_MAP, !v0_reg)

endmodule

// ===== tb/sv/quad_mesh_warp_address_map_checker.sv =====
// Checker for the warp address map: tracks loads and register writes, predicts each map result.
module quad_mesh_warp_address_map_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [12:0]  cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [151:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [55:0]  m_axis_tdata,
    output int           errors,
    output int           outstanding,
    output int           n_results,
    output int           n_inside,
    output int           n_white
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 8;
    localparam int WB = 16;
    localparam longint WONE = 64'sd1 <<< WB;
    localparam longint WSAT = 64'sd16 <<< WB;

    typedef struct packed {
        logic [11:0] dcol;
        logic [11:0] drow;
        logic        in_cell;
        logic        white;
        logic [11:0] scol;
        logic [11:0] srow;
    } addr_t;

    // Model copy of the block's registers.
    logic [12:0] img_w, img_h;
    longint bounds[4];
    longint cx[4];
    longint cy[4];
    addr_t expected_addrs[$];

    function automatic longint sx21(logic [20:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint cell_weight(longint pos, longint lo, longint hi);
        longint w;
        if (hi == lo) return 0;
        w = ((pos - lo) * WONE) / (hi - lo);
        if (w > WSAT) w = WSAT;
        if (w < -WSAT) w = -WSAT;
        return w;
    endfunction

    function automatic longint lerp(longint a, longint b, longint w);
        return ((WONE - w) * a + w * b) >>> WB;
    endfunction

    // Inverse-map one destination pixel through the current cell and corners.
    function automatic addr_t map_pixel(logic [11:0] c, logic [11:0] r);
        addr_t a;
        longint col, row, xmax, ymax, x0, y0, x1, y1, wx, wy, tx, ty, bx, by, px, py;
        col = c;
        row = r;
        xmax = (longint'(img_w) - 1) * 256;
        ymax = (longint'(img_h) - 1) * 256;
        x0 = bounds[0] < 0 ? 0 : bounds[0];
        y0 = bounds[1] < 0 ? 0 : bounds[1];
        x1 = bounds[2] < xmax ? bounds[2] : xmax;
        y1 = bounds[3] < ymax ? bounds[3] : ymax;
        a = '0;
        a.dcol = c;
        a.drow = r;
        if (!((x0 >>> FB) <= col && (col <<< FB) < x1 &&
              (y0 >>> FB) <= row && (row <<< FB) < y1))
            return a;
        a.in_cell = 1'b1;
        wx = cell_weight(col <<< FB, x0, x1);
        wy = cell_weight(row <<< FB, y0, y1);
        tx = lerp(cx[0], cx[1], wx);
        ty = lerp(cy[0], cy[1], wx);
        bx = lerp(cx[3], cx[2], wx);
        by = lerp(cy[3], cy[2], wx);
        px = lerp(tx, bx, wy);
        py = lerp(ty, by, wy);
        if (px < 0 || px > xmax || py < 0 || py > ymax) begin
            a.white = 1'b1;
            return a;
        end
        a.scol = 12'(px >>> FB);
        a.srow = 12'(py >>> FB);
        return a;
    endfunction

    assign outstanding = expected_addrs.size();

    // Follow register writes and input beats, then check result beats.
    always @(posedge aclk) begin
        addr_t got, want;
        if (!aresetn) begin
            img_w <= qmw_pkg::IMG_DIM_RESET;
            img_h <= qmw_pkg::IMG_DIM_RESET;
            for (int i = 0; i < 4; i++) begin
                bounds[i] = 0;
                cx[i] = 0;
                cy[i] = 0;
            end
            expected_addrs.delete();
            errors <= 0;
            n_results <= 0;
            n_inside <= 0;
            n_white <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == qmw_pkg::REG_WIDTH) img_w <= cfg_data;
                else img_h <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                case (s_axis_tuser)
                    qmw_pkg::OP_CELL: begin
                        bounds[0] = sx21(s_axis_tdata[64:44]);
                        bounds[1] = sx21(s_axis_tdata[85:65]);
                        bounds[2] = sx21(s_axis_tdata[106:86]);
                        bounds[3] = sx21(s_axis_tdata[127:107]);
                    end
                    qmw_pkg::OP_CORNER: begin
                        cx[s_axis_tdata[1:0]] = sx21(s_axis_tdata[22:2]);
                        cy[s_axis_tdata[1:0]] = sx21(s_axis_tdata[43:23]);
                    end
                    qmw_pkg::OP_MAP: expected_addrs.push_back(
                        map_pixel(s_axis_tdata[139:128], s_axis_tdata[151:140]));
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[24],
                       m_axis_tdata[25], m_axis_tdata[37:26], m_axis_tdata[49:38]};
                n_results <= n_results + 1;
                if (expected_addrs.size() == 0) begin
                    if (errors < 10) $display("ERROR: result beat with none expected: %h", got);
                    errors <= errors + 1;
                end else begin
                    want = expected_addrs.pop_front();
                    n_inside <= n_inside + want.in_cell;
                    n_white <= n_white + want.white;
                    if (got !== want) begin
                        if (errors < 10)
                            $display({"ERROR: dest (%0d,%0d) expected in=%b white=%b src=(%0d,%0d)",
                                      " got dest (%0d,%0d) in=%b white=%b src=(%0d,%0d)"},
                                     want.dcol, want.drow, want.in_cell, want.white, want.scol,
                                     want.srow, got.dcol, got.drow, got.in_cell, got.white,
                                     got.scol, got.srow);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb.sv =====
// Top of the warp address map testbench: clock, reset, stimulus phases and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_index;
    logic [12:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;
    int errors, outstanding, n_results, n_inside, n_white;
    int send_idle, recv_stall, beats_sent;
    logic [12:0] cur_w, cur_h;

    quad_mesh_warp_address_map_core u_top (.*);

    quad_mesh_warp_address_map_checker u_chk (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Receiver back-pressure.
    always @(posedge aclk) m_axis_tready <= ($urandom_range(99) >= recv_stall);

    initial begin
        #20ms;
        $display("FAIL quad_mesh_warp_address_map_core");
        $finish;
    end

    // Present one input beat and hold it until accepted.
    task automatic send_beat(logic [1:0] op, logic [151:0] d);
        if ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= d;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic send_cell(int l, int t, int r, int b);
        send_beat(qmw_pkg::OP_CELL, {24'd0, 21'(b), 21'(r), 21'(t), 21'(l), 44'd0});
    endtask

    task automatic send_corner(int i, int x, int y);
        send_beat(qmw_pkg::OP_CORNER, {108'd0, 21'(y), 21'(x), 2'(i)});
    endtask

    task automatic send_map(int c, int r);
        send_beat(qmw_pkg::OP_MAP, {12'(r), 12'(c), 128'd0});
    endtask

    // Stop sending and let every expected result drain out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [12:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == qmw_pkg::REG_WIDTH) cur_w = v;
        else cur_h = v;
    endtask

    function automatic int clip21(longint v);
        if (v > 1048575) return 1048575;
        if (v < -1048576) return -1048576;
        return int'(v);
    endfunction

    function automatic int rand_between(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // One well-formed scene: cell, four corners, then pixels around the cell.
    task automatic run_scene();
        int d, lim, l, t, r, b, spanc, spanr, nmap;
        d = (cur_w == 0 || cur_w > 4096) ? 4096 : cur_w;
        if (cur_h != 0 && cur_h < d) d = cur_h;
        lim = d * 256;
        l = clip21(rand_between(-lim / 8, lim));
        t = clip21(rand_between(-lim / 8, lim));
        r = clip21(longint'(l) + rand_between(-lim / 16, lim / 2));
        b = clip21(longint'(t) + rand_between(-lim / 16, lim / 2));
        send_cell(l, t, r, b);
        for (int i = 0; i < 4; i++)
            send_corner(i, clip21(rand_between(-lim / 8, lim + lim / 8)),
                        clip21(rand_between(-lim / 8, lim + lim / 8)));
        spanc = ((r - l) >>> 8) + 3;
        spanr = ((b - t) >>> 8) + 3;
        if (spanc < 3) spanc = 3;
        if (spanr < 3) spanr = 3;
        nmap = rand_between(6, 16);
        for (int k = 0; k < nmap; k++)
            send_map(((l >>> 8) - 1 + rand_between(0, spanc)) & 12'hFFF,
                     ((t >>> 8) - 1 + rand_between(0, spanr)) & 12'hFFF);
    endtask

    // Random phase: mostly scenes, some noise beats with any opcode.
    task automatic run_phase(int beats, int idle, int stall);
        int stop;
        send_idle = idle;
        recv_stall = stall;
        stop = beats_sent + beats;
        while (beats_sent < stop) begin
            if ($urandom_range(3) != 0) run_scene();
            else repeat (rand_between(1, 6))
                send_beat(2'($urandom_range(3)), {$urandom, $urandom, $urandom, $urandom,
                                                  24'($urandom)});
            if (beats_sent > stop - beats / 2 && beats_sent < stop - beats / 2 + 20)
                drain();
        end
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = qmw_pkg::REG_WIDTH;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = qmw_pkg::OP_CELL;
        m_axis_tready = 1'b1;
        send_idle = 0;
        recv_stall = 0;
        beats_sent = 0;
        cur_w = qmw_pkg::IMG_DIM_RESET;
        cur_h = qmw_pkg::IMG_DIM_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset state, extremes, degenerate cells, unused opcode.
        send_map(0, 0);
        send_cell(-1048576, -1048576, 1048575, 1048575);
        send_corner(0, -1048576, -1048576);
        send_corner(1, 1048575, -1048576);
        send_corner(2, 1048575, 1048575);
        send_corner(3, -1048576, 1048575);
        send_map(0, 0);
        send_map(4095, 4095);
        send_map(2048, 100);
        send_corner(0, 0, 0);
        send_corner(1, 4095 * 256, 0);
        send_corner(2, 4095 * 256, 4095 * 256);
        send_corner(3, 0, 4095 * 256);
        send_map(1000, 3000);
        send_cell(256, 256, 256, 2560);
        send_map(1, 5);
        send_cell(2560, 2560, 256, 256);
        send_map(5, 5);
        send_cell(2560, 2560, 2561, 2562);
        send_map(10, 10);
        send_beat(2'd3, {152{1'b1}});
        send_map(4095, 0);
        drain();

        run_phase(190, 0, 0);
        write_reg(qmw_pkg::REG_WIDTH, 13'd64);
        write_reg(qmw_pkg::REG_HEIGHT, 13'd48);
        run_phase(190, 59, 0);
        write_reg(qmw_pkg::REG_WIDTH, 13'd1);
        write_reg(qmw_pkg::REG_HEIGHT, 13'd8191);
        run_phase(190, 0, 59);
        write_reg(qmw_pkg::REG_WIDTH, 13'd0);
        write_reg(qmw_pkg::REG_HEIGHT, 13'd1);
        run_phase(160, 37, 37);
        write_reg(qmw_pkg::REG_WIDTH, 13'd4096);
        write_reg(qmw_pkg::REG_HEIGHT, 13'd4096);
        run_phase(160, 37, 37);

        $display("Sent %0d input beats over four image sizes and four idle/stall mixes.",
                 beats_sent);
        $display("Checked %0d map results: %0d inside a cell, %0d of those white fill.",
                 n_results, n_inside, n_white);
        if (errors == 0) begin
            $display("PASS quad_mesh_warp_address_map_core");
        end else begin
            $display("FAIL quad_mesh_warp_address_map_core");
        end
        $finish;
    end
endmodule
